// File: hdl/cce_pkg.sv
package cce_pkg;

    // width selection codes
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_WIDTH_MODE     = 3'd0;
    localparam logic [2:0] REG_POLYNOMIAL     = 3'd1;
    localparam logic [2:0] REG_INITIAL_VALUE  = 3'd2;
    localparam logic [2:0] REG_FINAL_XOR      = 3'd3;
    localparam logic [2:0] REG_REFLECT_INPUT  = 3'd4;
    localparam logic [2:0] REG_REFLECT_OUTPUT = 3'd5;

    localparam int ADDR_W = 5;

    // reset values of the configuration registers
    localparam logic [1:0]  RST_WIDTH_MODE    = WIDTH_32;
    localparam logic [31:0] RST_POLYNOMIAL    = 32'h04C1_1DB7;
    localparam logic [31:0] RST_INITIAL_VALUE = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_FINAL_XOR     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  width_mode;
        logic [31:0] polynomial;
        logic [31:0] final_xor;
        logic        reflect_input;
        logic        reflect_output;
    } cfg_t;

endpackage

// File: hdl/configurable_crc_engine.sv
// a closing byte passes through the input register, then the result register, before its checksum is valid
// throughput: one byte per cycle unless stalled; the crc update is one unrolled 8-step combinational shift-xor
// a closing byte is held in the input register only while a finished checksum waits downstream
// reset: async active-low; clears valid flags and message state, loads config reset values
// the running crc has no reset, it is loaded from initial_value at each message start
module configurable_crc_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    // item input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_message,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [31:0]                 checksum,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cce_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // configuration registers
    logic [1:0]    width_mode_reg;
    logic [31:0]   polynomial_reg;
    logic [31:0]   initial_value_reg;
    logic [31:0]   final_xor_reg;
    logic          reflect_input_reg;
    logic          reflect_output_reg;

    logic          cfg_write;
    logic [2:0]    cfg_index;
    cce_pkg::cfg_t cfg;

    // input register
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [7:0]    s1_byte_reg;
    logic          s1_eom_reg;

    // message state
    logic [31:0]   running_crc_reg;
    logic          in_message_reg;

    // result register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   checksum_reg;

    logic          in_accept;
    logic          s1_fire;
    logic [31:0]   crc_start;
    logic [31:0]   crc_out;
    logic [31:0]   checksum_comb;

    //------------------------------------------------------------------
    // configuration port: always ready, writes land on the access cycle
    //------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_mode_reg     <= cce_pkg::RST_WIDTH_MODE;
            polynomial_reg     <= cce_pkg::RST_POLYNOMIAL;
            initial_value_reg  <= cce_pkg::RST_INITIAL_VALUE;
            final_xor_reg      <= cce_pkg::RST_FINAL_XOR;
            reflect_input_reg  <= 1'b1;
            reflect_output_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cce_pkg::REG_WIDTH_MODE:     width_mode_reg     <= pwdata[1:0];
                cce_pkg::REG_POLYNOMIAL:     polynomial_reg     <= pwdata;
                cce_pkg::REG_INITIAL_VALUE:  initial_value_reg  <= pwdata;
                cce_pkg::REG_FINAL_XOR:      final_xor_reg      <= pwdata;
                cce_pkg::REG_REFLECT_INPUT:  reflect_input_reg  <= pwdata[0];
                cce_pkg::REG_REFLECT_OUTPUT: reflect_output_reg <= pwdata[0];
                default:                     ;  // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            cce_pkg::REG_WIDTH_MODE:     prdata = {30'd0, width_mode_reg};
            cce_pkg::REG_POLYNOMIAL:     prdata = polynomial_reg;
            cce_pkg::REG_INITIAL_VALUE:  prdata = initial_value_reg;
            cce_pkg::REG_FINAL_XOR:      prdata = final_xor_reg;
            cce_pkg::REG_REFLECT_INPUT:  prdata = {31'd0, reflect_input_reg};
            cce_pkg::REG_REFLECT_OUTPUT: prdata = {31'd0, reflect_output_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg.width_mode     = width_mode_reg;
    assign cfg.polynomial     = polynomial_reg;
    assign cfg.final_xor      = final_xor_reg;
    assign cfg.reflect_input  = reflect_input_reg;
    assign cfg.reflect_output = reflect_output_reg;

    //------------------------------------------------------------------
    // handshake
    // the input register only stalls when it holds a closing byte and
    // the result register is still occupied by an untaken checksum
    //------------------------------------------------------------------
    assign s1_fire   = s1_valid_reg && !(s1_eom_reg && out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload of the input register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_eom_reg  <= end_of_message;
        end
    end

    //------------------------------------------------------------------
    // crc update: a new message starts from initial_value
    //------------------------------------------------------------------
    assign crc_start = in_message_reg ? running_crc_reg : initial_value_reg;

    cce_byte_step u_step (
        .cfg       (cfg),
        .crc_in    (crc_start),
        .data_byte (s1_byte_reg),
        .crc_out   (crc_out),
        .checksum  (checksum_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            in_message_reg <= !s1_eom_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            running_crc_reg <= crc_out;
        end
    end

    //------------------------------------------------------------------
    // result register
    //------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_eom_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_eom_reg)
        begin
            checksum_reg <= checksum_comb;
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    // a closing byte ends the message
    a_eom_closes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_eom_reg |=> !in_message_reg)
        else $error("message still open after closing byte");

    // a non-closing byte leaves a message open
    a_byte_opens: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_eom_reg |=> in_message_reg)
        else $error("message not open after data byte");

    // a closing byte never overwrites a checksum that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(checksum_reg))
        else $error("held checksum lost or changed");

    // an 8-bit checksum is zero-extended
    a_zero_ext8: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (width_mode_reg == cce_pkg::WIDTH_8) |-> checksum_reg[31:8] == 24'd0)
        else $error("8-bit checksum not zero-extended");

endmodule

// File: hdl/cce_byte_step.sv
module cce_byte_step (
    input  cce_pkg::cfg_t cfg,
    input  logic [31:0]   crc_in,
    input  logic [7:0]    data_byte,
    output logic [31:0]   crc_out,
    output logic [31:0]   checksum
);

    logic [31:0] mask;
    logic [31:0] poly;
    logic [7:0]  byte_in;
    logic [31:0] crc_step [0:8];
    logic [31:0] crc_rev;
    logic        msb;

    always_comb
    begin
        case (cfg.width_mode)
            cce_pkg::WIDTH_8:  mask = 32'h0000_00FF;
            cce_pkg::WIDTH_16: mask = 32'h0000_FFFF;
            default:           mask = 32'hFFFF_FFFF;
        endcase
    end

    assign poly = cfg.polynomial & mask;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_in[i] = cfg.reflect_input ? data_byte[7 - i] : data_byte[i];
        end
    end

    // byte goes into the top byte of the register at the selected width,
    // then eight msb-first shift steps
    always_comb
    begin
        case (cfg.width_mode)
            cce_pkg::WIDTH_8:  crc_step[0] = (crc_in & mask) ^ {24'd0, byte_in};
            cce_pkg::WIDTH_16: crc_step[0] = (crc_in & mask) ^ {16'd0, byte_in, 8'd0};
            default:           crc_step[0] = (crc_in & mask) ^ {byte_in, 24'd0};
        endcase
        msb = 1'b0;
        for (int s = 0; s < 8; s++)
        begin
            case (cfg.width_mode)
                cce_pkg::WIDTH_8:  msb = crc_step[s][7];
                cce_pkg::WIDTH_16: msb = crc_step[s][15];
                default:           msb = crc_step[s][31];
            endcase
            crc_step[s + 1] = ({crc_step[s][30:0], 1'b0} ^ (msb ? poly : 32'd0)) & mask;
        end
    end

    assign crc_out = crc_step[8];

    // output reflection over the selected width
    always_comb
    begin
        crc_rev = 32'd0;
        case (cfg.width_mode)
            cce_pkg::WIDTH_8:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    crc_rev[i] = crc_out[7 - i];
                end
            end
            cce_pkg::WIDTH_16:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    crc_rev[i] = crc_out[15 - i];
                end
            end
            default:
            begin
                for (int i = 0; i < 32; i++)
                begin
                    crc_rev[i] = crc_out[31 - i];
                end
            end
        endcase
    end

    assign checksum = ((cfg.reflect_output ? crc_rev : crc_out) ^ cfg.final_xor) & mask;

endmodule
